FILE: hdl/msjs_pkg.sv
// shared types and constants of the multi-slot job server
// no dependencies; imported by msjs_ctrl, msjs_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package msjs_pkg;

  // fixed field widths
  localparam int ACT_W      = 4;
  localparam int CAP_W      = 5;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SLOT_OUT_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_TICKS  = 2'd2;

  // input function codes
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_SUBMIT = 1'b1;

  // event kinds
  localparam logic EV_DROP = 1'b0;
  localparam logic EV_DONE = 1'b1;

  typedef struct packed {
    logic capture;  // latch the accepted item
    logic push;     // drop head if full, append tag
    logic start;    // start queue head on an idle slot
    logic dec;      // count down busy slots, latch finishing set
    logic emit;     // report lowest finishing slot and refill
  } msjs_cmd_t;

  typedef struct packed {
    logic need_drop;
    logic done_any;
    logic done_last;
    logic out_free;
  } msjs_status_t;

endpackage

`default_nettype wire

FILE: hdl/msjs_ctrl.sv
// sequencing state machine of the job server
// depends on msjs_pkg; drives msjs_dp through command and status structs
`timescale 1ns / 1ps
`default_nettype none

module msjs_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  wire                    in_func_i,
  output logic                   in_ready_o,
  input  msjs_pkg::msjs_status_t status_i,
  output msjs_pkg::msjs_cmd_t    cmd_o
);
  import msjs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB_PUSH,
    ST_SUB_START,
    ST_TICK_DEC,
    ST_TICK_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (in_func_i == FUNC_SUBMIT) ? ST_SUB_PUSH : ST_TICK_DEC;
        end
      end
      ST_SUB_PUSH: begin
        // a drop needs the output register
        if (!status_i.need_drop || status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_SUB_START;
        end
      end
      ST_SUB_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_TICK_DEC: begin
        cmd_o.dec = 1'b1;
        state_d   = ST_TICK_EMIT;
      end
      ST_TICK_EMIT: begin
        if (!status_i.done_any) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.done_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // results are only loaded into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("emit while output register busy");

  // accepting an item moves the sequencer out of idle, which drops ready
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after accept");

endmodule

`default_nettype wire

FILE: hdl/msjs_dp.sv
// datapath of the job server: config registers, tag queue, slot state, output register
// depends on msjs_pkg; controlled by msjs_ctrl
`timescale 1ns / 1ps
`default_nettype none

module msjs_dp #(
  parameter int MAX_SLOTS   = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  msjs_pkg::msjs_cmd_t                  cmd_i,
  output msjs_pkg::msjs_status_t               status_o,
  input  wire [TAG_BITS-1:0]                   in_tag_i,
  input  wire                                  cfg_we_i,
  input  wire [msjs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire [msjs_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire                                  out_ready_i,
  output logic                                 out_valid_o,
  output logic                                 out_kind_o,
  output logic [TAG_BITS-1:0]                  out_tag_o,
  output logic [msjs_pkg::SLOT_OUT_W-1:0]      out_slot_o,
  output logic                                 out_last_o
);
  import msjs_pkg::*;

  localparam int IW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW = CW + 1;
  localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SCW  = $clog2(MAX_SLOTS + 1);

  // configuration
  logic [ACT_W-1:0]  act_q;
  logic [CAP_W-1:0]  cap_q;
  logic [TICK_W-1:0] ticks_q;

  // queue
  logic [TAG_BITS-1:0] qstore_q [QUEUE_DEPTH];
  logic [IW-1:0]       head_q, head_d, head_inc, tail;
  logic [CW-1:0]       count_q, count_d, count_ad;
  logic [SUMW-1:0]     tail_sum;
  logic                pushok;

  // slots
  logic [MAX_SLOTS-1:0] busy_q, busy_d, done_q, done_d, slot_en, free_vec;
  logic [MAX_SLOTS-1:0] emit_oh, rem_zero;
  logic [TICK_W-1:0]    rem_q [MAX_SLOTS];
  logic [TICK_W-1:0]    rem_d [MAX_SLOTS];
  logic [TAG_BITS-1:0]  job_q [MAX_SLOTS];
  logic [SW-1:0]        emit_idx, start_idx;
  logic                 start_ok;

  logic [TAG_BITS-1:0] item_tag_q;
  logic [SCW-1:0]      slots_eff;
  logic [CW-1:0]       cap_eff;
  logic [TICK_W-1:0]   ticks_eff;
  logic                need_drop, out_load, out_free;

  function automatic logic [SW-1:0] lowest(input logic [MAX_SLOTS-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
      if (v[k]) r = SW'(k);
    end
    return r;
  endfunction

  // clamped configuration
  assign slots_eff = (act_q == '0) ? SCW'(1) :
                     ((32'(act_q) > 32'(MAX_SLOTS)) ? SCW'(MAX_SLOTS) : SCW'(act_q));
  assign cap_eff   = (cap_q == '0) ? CW'(1) :
                     ((32'(cap_q) > 32'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(cap_q));
  assign ticks_eff = (ticks_q == '0) ? TICK_W'(1) : ticks_q;

  // queue pointers
  assign head_inc  = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IW'(1);
  assign tail_sum  = SUMW'(head_q) + SUMW'(count_q);
  assign tail      = (tail_sum >= SUMW'(QUEUE_DEPTH)) ? IW'(tail_sum - SUMW'(QUEUE_DEPTH))
                                                      : IW'(tail_sum);
  assign need_drop = (count_q >= cap_eff) && (count_q != '0);
  assign count_ad  = count_q - CW'(need_drop);
  assign pushok    = 32'(count_ad) < 32'(QUEUE_DEPTH);

  // slot selection
  always_comb begin
    for (int k = 0; k < MAX_SLOTS; k++) begin
      slot_en[k]  = 32'(k) < 32'(slots_eff);
      rem_zero[k] = (rem_q[k] == '0);
    end
    emit_idx = lowest(done_q);
    for (int k = 0; k < MAX_SLOTS; k++) begin
      emit_oh[k] = (SW'(k) == emit_idx);
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    for (int k = 0; k < MAX_SLOTS; k++) begin
      rem_d[k] = rem_q[k];
    end
    if (cmd_i.dec) begin
      for (int k = 0; k < MAX_SLOTS; k++) begin
        if (busy_q[k] && !rem_zero[k]) rem_d[k] = rem_q[k] - TICK_W'(1);
        done_d[k] = busy_q[k] && (rem_q[k] <= TICK_W'(1));
      end
    end
    if (cmd_i.emit) begin
      busy_d = busy_d & ~emit_oh;
      done_d = done_d & ~emit_oh;
    end
    // refill after a submit or a completion, using the freed slot too
    free_vec  = ~busy_d & slot_en;
    start_idx = lowest(free_vec);
    start_ok  = (cmd_i.start || cmd_i.emit) && (count_q != '0) && (|free_vec);
    if (start_ok) begin
      busy_d[start_idx] = 1'b1;
      rem_d[start_idx]  = ticks_eff;
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.push) begin
      head_d  = need_drop ? head_inc : head_q;
      count_d = count_ad + CW'(pushok);
    end else if (start_ok) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end
  end

  // output register
  assign out_free = !out_valid_o || out_ready_i;
  assign out_load = (cmd_i.push && need_drop) || cmd_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= ACT_W'(1);
      cap_q       <= CAP_W'(10);
      ticks_q     <= TICK_W'(1);
      head_q      <= '0;
      count_q     <= '0;
      busy_q      <= '0;
      done_q      <= '0;
      out_valid_o <= 1'b0;
      for (int k = 0; k < MAX_SLOTS; k++) begin
        rem_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ACTIVE_SLOTS:   act_q   <= cfg_data_i[ACT_W-1:0];
          CFG_QUEUE_CAPACITY: cap_q   <= cfg_data_i[CAP_W-1:0];
          CFG_PROCESS_TICKS:  ticks_q <= cfg_data_i[TICK_W-1:0];
          default: ;
        endcase
      end
      head_q      <= head_d;
      count_q     <= count_d;
      busy_q      <= busy_d;
      done_q      <= done_d;
      out_valid_o <= out_load || (out_valid_o && !out_ready_i);
      for (int k = 0; k < MAX_SLOTS; k++) begin
        rem_q[k] <= rem_d[k];
      end
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_tag_q <= in_tag_i;
    if (cmd_i.push && pushok) qstore_q[tail] <= item_tag_q;
    if (start_ok) job_q[start_idx] <= qstore_q[head_q];
    if (cmd_i.emit) begin
      out_kind_o <= EV_DONE;
      out_tag_o  <= job_q[emit_idx];
      out_slot_o <= SLOT_OUT_W'(emit_idx);
      out_last_o <= ((done_q & ~emit_oh) == '0);
    end else if (cmd_i.push && need_drop) begin
      out_kind_o <= EV_DROP;
      out_tag_o  <= qstore_q[head_q];
      out_slot_o <= '0;
      out_last_o <= 1'b1;
    end
  end

  assign status_o.need_drop = need_drop;
  assign status_o.done_any  = |done_q;
  assign status_o.done_last = ((done_q & ~emit_oh) == '0);
  assign status_o.out_free  = out_free;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q & ~busy_q) == '0)
    else $error("finishing slot not busy");

  a_zero_rem_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q & rem_zero & ~done_q) == '0)
    else $error("busy slot expired without completion");

endmodule

`default_nettype wire

FILE: hdl/multi_slot_job_server_drop_oldest_core.sv
// top level of the multi-slot job server with a drop-oldest queue
// depends on msjs_pkg, msjs_ctrl and msjs_dp
`timescale 1ns / 1ps
`default_nettype none

// usage
// - slave stream carries one transaction per input: tuser = func (0 tick, 1 submit),
//   tdata = job tag; a submit appends the tag, dropping the queue head when full
// - master stream carries events: tuser = kind (0 drop, 1 done), tdata = tag and slot,
//   tlast marks the final event caused by one input
// - config channel writes active_slots (0), queue_capacity (1), process_ticks (2);
//   write only while the server is idle, it is always ready
// - sequencing: a submit passes acceptance, push and start; the push waits for a
//   free output register when it drops the head; a tick passes acceptance,
//   countdown and emit, where completing slots are reported one at a time, each
//   refilled by the single shared refill unit, or returns to idle when none completes
// - events leave through a one-entry output register, so the next input can be
//   accepted while the last event waits; an event that finds the register still
//   full holds the sequencer until the receiver takes it
// - reset empties the queue, idles all slots and loads the register defaults
//   (1 slot, capacity 10, 1 tick); no clearing pass is needed

module multi_slot_job_server_drop_oldest_core #(
  parameter int MAX_SLOTS   = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16,
  localparam int InW  = ((TAG_BITS + 7) / 8) * 8,
  localparam int OutW = ((TAG_BITS + msjs_pkg::SLOT_OUT_W + 7) / 8) * 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [InW-1:0]                    s_axis_tdata,   // job_tag
  input  wire                              s_axis_tuser,   // func
  // event stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [OutW-1:0]                  m_axis_tdata,   // event_tag, slot_index
  output logic                             m_axis_tuser,   // event_kind
  output logic                             m_axis_tlast,
  // configuration writes
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [msjs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [msjs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import msjs_pkg::*;

  msjs_cmd_t           cmd;
  msjs_status_t        status;
  logic [TAG_BITS-1:0] out_tag;
  logic [SLOT_OUT_W-1:0] out_slot;

  // config writes go straight into the datapath registers, no backpressure
  assign cfg_ready_o = 1'b1;

  msjs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  msjs_dp #(
    .MAX_SLOTS   (MAX_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_tag_i    (s_axis_tdata[TAG_BITS-1:0]),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_tag_o   (out_tag),
    .out_slot_o  (out_slot),
    .out_last_o  (m_axis_tlast)
  );

  // tag in the low bits, slot index above, zero fill to whole bytes
  assign m_axis_tdata = OutW'({out_slot, out_tag});

endmodule

`default_nettype wire
